// File: hdl/spsa_pkg.sv
// Shared types, constants and coil/delay tables of the stepper phase sequencer.
`default_nettype none
package spsa_pkg;

   // Field widths.
   localparam int REQ_W       = 3;
   localparam int POS_W       = 32;
   localparam int COIL_W      = 4;
   localparam int PHASE_W     = 3;
   localparam int ACCEL_IDX_W = 5;
   localparam int COUNT_W     = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 1;

   // Acceleration ramp length and delay table size.
   localparam int ACCEL_ENTRIES = 23;
   localparam int ROM_DEPTH     = 23;
   localparam logic [ACCEL_IDX_W-1:0] ACCEL_START_IDX = ACCEL_IDX_W'(ACCEL_ENTRIES - 1);

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_STEP        = 3'd0;
   localparam logic [REQ_W-1:0] REQ_MOVE        = 3'd1;
   localparam logic [REQ_W-1:0] REQ_ACCEL_START = 3'd2;
   localparam logic [REQ_W-1:0] REQ_ACCEL_END   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_SET_POS     = 3'd4;
   localparam logic [REQ_W-1:0] REQ_POWER_OFF   = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT    = 1'b1;

   // Delay loaded into the countdown at each ramp entry.
   localparam logic [COUNT_W-1:0] ACCEL_DELAY_ROM [ROM_DEPTH] = '{
      4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4,
      4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd8, 4'd8, 4'd10, 4'd10, 4'd10
   };

   // Coil patterns, bit0 blue, bit1 pink, bit2 yellow, bit3 orange.
   localparam logic [COIL_W-1:0] HALF_FW [8] = '{4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9, 4'h1};
   localparam logic [COIL_W-1:0] HALF_BW [8] = '{4'h1, 4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3};
   localparam logic [COIL_W-1:0] FULL_FW [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
   localparam logic [COIL_W-1:0] FULL_BW [4] = '{4'h9, 4'hC, 4'h6, 4'h3};

   typedef struct packed {
      logic [REQ_W-1:0]        req_type;
      logic                    forward;
      logic signed [POS_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic step_mode;
      logic invert_direction;
   } cfg_type;

   typedef struct packed {
      logic [COIL_W-1:0]       coils;
      logic                    coils_changed;
      logic                    done_res;
      logic signed [POS_W-1:0] position;
   } rsp_type;

   // Delay ROM read; entries past the table read as zero.
   function automatic logic [COUNT_W-1:0] accel_delay(input logic [ACCEL_IDX_W-1:0] idx);
      logic [COUNT_W-1:0] delay;
      delay = '0;
      for (int i = 0; i < ROM_DEPTH; i++) begin
         if (idx == ACCEL_IDX_W'(i)) begin
            delay = ACCEL_DELAY_ROM[i];
         end
      end
      return delay;
   endfunction

   // Coil pattern for the given mode, table direction and phase.
   function automatic logic [COIL_W-1:0] coil_pattern(input logic full_step,
                                                      input logic use_fw,
                                                      input logic [PHASE_W-1:0] phase);
      logic [COIL_W-1:0] pattern;
      if (full_step) begin
         pattern = use_fw ? FULL_FW[phase[1:0]] : FULL_BW[phase[1:0]];
      end else begin
         pattern = use_fw ? HALF_FW[phase] : HALF_BW[phase];
      end
      return pattern;
   endfunction

endpackage
`default_nettype wire

// File: hdl/spsa_core.sv
// Sequencer state registers and the per-request next-state and result logic.
`default_nettype none
module spsa_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire spsa_pkg::cmd_type cmd,
   input  wire spsa_pkg::cfg_type cfg,
   output spsa_pkg::rsp_type      rsp
);
   import spsa_pkg::*;

   logic signed [POS_W-1:0] pos_ff, pos_in;
   logic [PHASE_W-1:0]      phase_ff, phase_in;
   logic [ACCEL_IDX_W-1:0]  accel_idx_ff, accel_idx_in;
   logic [COUNT_W-1:0]      countdown_ff, countdown_in;
   logic [COIL_W-1:0]       coil_ff, coil_in;

   logic                    move_up;
   logic                    move_down;
   logic                    step_fwd;
   logic                    wrap;
   logic [PHASE_W-1:0]      step_phase;
   logic [PHASE_W-1:0]      step_phase_next;
   logic [COIL_W-1:0]       step_coils;
   logic signed [POS_W-1:0] step_pos;
   logic [ACCEL_IDX_W-1:0]  accel_idx_dec;
   logic                    changed;
   logic                    done;

   // Direction of a move toward the target.
   assign move_up   = pos_ff < $signed(cmd.value);
   assign move_down = pos_ff > $signed(cmd.value);
   assign step_fwd  = (cmd.req_type == REQ_MOVE) ? move_up : cmd.forward;

   // One step: coil lookup, phase advance and position update on sequence wrap.
   always_comb begin
      if (cfg.step_mode) begin
         step_phase = {1'b0, phase_ff[1:0]};
         wrap       = (phase_ff[1:0] == 2'd3);
      end else begin
         step_phase = phase_ff;
         wrap       = (phase_ff == 3'd7);
      end
      step_coils      = coil_pattern(cfg.step_mode, step_fwd ^ cfg.invert_direction, step_phase);
      step_phase_next = wrap ? '0 : step_phase + 3'd1;
      if (wrap) begin
         step_pos = step_fwd ? pos_ff + 32'sd1 : pos_ff - 32'sd1;
      end else begin
         step_pos = pos_ff;
      end
   end

   assign accel_idx_dec = accel_idx_ff - 5'd1;

   // Request decode.
   always_comb begin
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      accel_idx_in = accel_idx_ff;
      countdown_in = countdown_ff;
      coil_in      = coil_ff;
      changed      = 1'b0;
      done         = 1'b0;
      unique case (cmd.req_type)
         REQ_STEP: begin
            if (accel_idx_ff != '0 && countdown_ff != '0) begin
               // Still waiting out the acceleration delay.
               countdown_in = countdown_ff - 4'd1;
            end else begin
               if (accel_idx_ff != '0) begin
                  accel_idx_in = accel_idx_dec;
                  countdown_in = accel_delay(accel_idx_dec);
               end
               pos_in   = step_pos;
               phase_in = step_phase_next;
               coil_in  = step_coils;
               changed  = 1'b1;
               done     = (step_phase_next == '0);
            end
         end
         REQ_MOVE: begin
            changed = 1'b1;
            if (move_up || move_down) begin
               pos_in   = step_pos;
               phase_in = step_phase_next;
               coil_in  = step_coils;
            end else begin
               // Target reached: power the coils off.
               coil_in  = '0;
               phase_in = '0;
               done     = 1'b1;
            end
         end
         REQ_ACCEL_START: begin
            accel_idx_in = ACCEL_START_IDX;
            countdown_in = accel_delay(ACCEL_START_IDX);
         end
         REQ_ACCEL_END: begin
            accel_idx_in = '0;
            countdown_in = '0;
         end
         REQ_SET_POS: begin
            pos_in = cmd.value;
         end
         REQ_POWER_OFF: begin
            coil_in  = '0;
            phase_in = '0;
            changed  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // State update on each executed request.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         phase_ff     <= '0;
         accel_idx_ff <= '0;
         countdown_ff <= '0;
         coil_ff      <= '0;
      end else if (fire) begin
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         accel_idx_ff <= accel_idx_in;
         countdown_ff <= countdown_in;
         coil_ff      <= coil_in;
      end
   end

   assign rsp.coils         = coil_in;
   assign rsp.coils_changed = changed;
   assign rsp.done_res      = done;
   assign rsp.position      = pos_in;

endmodule
`default_nettype wire

// File: hdl/stepper_phase_sequencer_accel.sv
// Top level of the unipolar stepper phase sequencer with step acceleration.
//
// Requests (step tick, move, accel start/end, set position, power off) enter
// on the req_ valid/ready channel; each one produces exactly one transaction
// on the rsp_ channel carrying the coil drive, a coil-written flag, a done
// flag and the position counter after the request.
// A request is captured in an input register, executed by the sequencer core
// once the output register can take its result, and its result sits in that
// output register, which drives rsp_valid. One request per cycle is sustained
// while the receiver keeps rsp_ready high; the limit is the single state
// update per cycle in the core.
// When the receiver stalls, the result holds in the output register, the
// input register keeps one more request, and req_ready drops after that.
// The csr_ channel writes step_mode (index 0) and invert_direction (index 1);
// it is always ready and should be used only while the block is idle.
// Synchronous reset clears position, phase, acceleration state, coils (all
// off), both configuration bits and the valid flags of both pipeline registers.
`default_nettype none
module stepper_phase_sequencer_accel (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request channel.
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [spsa_pkg::REQ_W-1:0]          req_type,
   input  wire logic                                req_forward,
   input  wire logic signed [spsa_pkg::POS_W-1:0]   req_value,
   // Result channel.
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [spsa_pkg::COIL_W-1:0]              rsp_coils,
   output logic                                     rsp_coils_changed,
   output logic                                     rsp_done_res,
   output logic signed [spsa_pkg::POS_W-1:0]        rsp_position,
   // Configuration channel.
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [spsa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [spsa_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import spsa_pkg::*;

   logic    in_valid_ff;
   cmd_type cmd_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   cfg_type cfg_ff;
   rsp_type core_rsp;
   logic    fire;

   // Execute when a request is held and the output register can take its result.
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign csr_ready = 1'b1;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff.req_type <= req_type;
         cmd_ff.forward  <= req_forward;
         cmd_ff.value    <= req_value;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STEP_MODE: cfg_ff.step_mode        <= csr_wdata[0];
            CSR_INVERT:    cfg_ff.invert_direction <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   spsa_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .cmd   (cmd_ff),
      .cfg   (cfg_ff),
      .rsp   (core_rsp)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_coils         = rsp_ff.coils;
   assign rsp_coils_changed = rsp_ff.coils_changed;
   assign rsp_done_res      = rsp_ff.done_res;
   assign rsp_position      = rsp_ff.position;

endmodule
`default_nettype wire
